### hw/rtl/cffbp_pkg.sv
// Shared types and codes for the class first-fit bin packer.
`default_nettype none

package cffbp_pkg;

   localparam int SIZE_W  = 16;
   localparam int TAG_W   = 16;
   localparam int CLS_W   = 3;
   localparam int IDX_W   = 4;
   localparam int USED_W  = 5;
   localparam int STAT_W  = 2;

   localparam logic [SIZE_W-1:0] CAP_RESET = 16'd2560;

   localparam logic CMD_PACK  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [1:0] KIND_PACK     = 2'd0;
   localparam logic [1:0] KIND_CLEAR    = 2'd1;
   localparam logic [1:0] KIND_OVERSIZE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_PLACED   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERSIZE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_BIN   = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CLS_W-1:0]  item_class;
      logic [SIZE_W-1:0] item_size;
      logic [TAG_W-1:0]  item_tag;
      logic              last_item;
   } job_type;

   typedef struct packed {
      logic [TAG_W-1:0]  placed_tag;
      logic [IDX_W-1:0]  bin_index;
      logic              opened_new;
      logic [STAT_W-1:0] status;
      logic [SIZE_W-1:0] fill_after;
      logic [USED_W-1:0] bins_used;
      logic              last_out;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/cffbp_front.sv
// Front stage: accept items, classify them and hold them for the queue.
`default_nettype none

module cffbp_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_command,
   input  wire  [cffbp_pkg::CLS_W-1:0]   req_item_class,
   input  wire  [cffbp_pkg::SIZE_W-1:0]  req_item_size,
   input  wire  [cffbp_pkg::TAG_W-1:0]   req_item_tag,
   input  wire                           req_last_item,
   input  wire  [cffbp_pkg::SIZE_W-1:0]  capacity,
   output logic                          push_valid,
   input  wire                           push_ready,
   output cffbp_pkg::job_type            push_job
);

   logic               valid_ff, valid_in;
   cffbp_pkg::job_type job_ff, job_in;
   logic               take;

   assign req_stall  = valid_ff && !push_ready;
   assign take       = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_job   = job_ff;

   always_comb begin
      job_in = job_ff;
      if (take) begin
         job_in.item_class = req_item_class;
         job_in.item_size  = req_item_size;
         job_in.item_tag   = req_item_tag;
         job_in.last_item  = req_last_item;
         priority if (req_command == cffbp_pkg::CMD_CLEAR) begin
            job_in.kind = cffbp_pkg::KIND_CLEAR;
         end else if (req_item_size > capacity) begin
            job_in.kind = cffbp_pkg::KIND_OVERSIZE;
         end else begin
            job_in.kind = cffbp_pkg::KIND_PACK;
         end
      end
      valid_in = take || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

`default_nettype wire

### hw/rtl/cffbp_queue.sv
// Two-entry queue between the front and back stages.
`default_nettype none

module cffbp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  cffbp_pkg::job_type  push_job,
   output logic                pop_valid,
   input  wire                 pop,
   output cffbp_pkg::job_type  pop_job
);

   cffbp_pkg::job_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cffbp_back.sv
// Back stage: scan the bins first-fit, update the bin store and register the result.
`default_nettype none

module cffbp_back #(
   parameter int MAX_BINS   = 16,
   parameter int CLASS_BITS = 3
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           job_valid,
   output logic                          job_pop,
   input  cffbp_pkg::job_type            job,
   input  wire  [cffbp_pkg::SIZE_W-1:0]  capacity,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output cffbp_pkg::result_type         rsp_result
);

   localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CW = $clog2(MAX_BINS + 1);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic [CLASS_BITS-1:0]        class_mem [MAX_BINS];
   logic [cffbp_pkg::SIZE_W-1:0] fill_mem  [MAX_BINS];
   logic [CLASS_BITS-1:0]        rd_class_ff;
   logic [cffbp_pkg::SIZE_W-1:0] rd_fill_ff;

   logic                         state_ff, state_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CLASS_BITS-1:0]        cls_ff, cls_in;
   logic [cffbp_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [cffbp_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cffbp_pkg::result_type        rsp_ff, rsp_in;

   logic [IW-1:0]                rd_addr;
   logic                         we;
   logic [IW-1:0]                wr_addr;
   logic [CLASS_BITS-1:0]        wr_class;
   logic [cffbp_pkg::SIZE_W-1:0] wr_fill;
   logic                         load;
   logic                         out_free;
   logic                         fit;
   logic [cffbp_pkg::SIZE_W:0]   sum;
   logic [CW:0]                  idx_next;
   logic [CLASS_BITS+cffbp_pkg::CLS_W-1:0] cls_ext;
   logic [IW+cffbp_pkg::IDX_W-1:0]         bin_ext;
   logic [CW+cffbp_pkg::USED_W-1:0]        used_ext;
   logic [IW-1:0]                res_idx;
   logic                         res_opened;
   logic [cffbp_pkg::STAT_W-1:0] res_status;
   logic [cffbp_pkg::SIZE_W-1:0] res_fill;
   logic [cffbp_pkg::TAG_W-1:0]  res_tag;
   logic                         res_last;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign cls_ext    = {{CLASS_BITS{1'b0}}, job.item_class};
   assign sum        = {1'b0, rd_fill_ff} + {1'b0, size_ff};
   assign fit        = (rd_class_ff == cls_ff) && (sum <= {1'b0, capacity});
   assign idx_next   = {1'b0, CW'(idx_ff)} + {{CW{1'b0}}, 1'b1};

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      cls_in     = cls_ff;
      size_in    = size_ff;
      tag_in     = tag_ff;
      last_in    = last_ff;
      job_pop    = 1'b0;
      rd_addr    = '0;
      we         = 1'b0;
      wr_addr    = '0;
      wr_class   = cls_ff;
      wr_fill    = size_ff;
      load       = 1'b0;
      res_idx    = '0;
      res_opened = 1'b0;
      res_status = cffbp_pkg::STAT_PLACED;
      res_fill   = '0;
      res_tag    = tag_ff;
      res_last   = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && out_free) begin
               job_pop  = 1'b1;
               cls_in   = cls_ext[CLASS_BITS-1:0];
               size_in  = job.item_size;
               tag_in   = job.item_tag;
               last_in  = job.last_item;
               res_tag  = job.item_tag;
               res_last = job.last_item;
               priority case (job.kind)
                  cffbp_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     load     = 1'b1;
                  end
                  cffbp_pkg::KIND_OVERSIZE: begin
                     res_status = cffbp_pkg::STAT_OVERSIZE;
                     load       = 1'b1;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        we         = 1'b1;
                        wr_class   = cls_ext[CLASS_BITS-1:0];
                        wr_fill    = job.item_size;
                        count_in   = CW'(1);
                        res_opened = 1'b1;
                        res_fill   = job.item_size;
                        load       = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         default: begin
            priority if (fit) begin
               we       = 1'b1;
               wr_addr  = idx_ff;
               wr_class = rd_class_ff;
               wr_fill  = sum[cffbp_pkg::SIZE_W-1:0];
               res_idx  = idx_ff;
               res_fill = sum[cffbp_pkg::SIZE_W-1:0];
               load     = 1'b1;
               state_in = S_IDLE;
            end else if (idx_next < {1'b0, count_ff}) begin
               idx_in  = idx_next[IW-1:0];
               rd_addr = idx_next[IW-1:0];
            end else if (count_ff == CW'(MAX_BINS)) begin
               res_status = cffbp_pkg::STAT_NO_BIN;
               load       = 1'b1;
               state_in   = S_IDLE;
            end else begin
               we         = 1'b1;
               wr_addr    = count_ff[IW-1:0];
               count_in   = count_ff + CW'(1);
               res_idx    = count_ff[IW-1:0];
               res_opened = 1'b1;
               res_fill   = size_ff;
               load       = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
      bin_ext  = {{cffbp_pkg::IDX_W{1'b0}}, res_idx};
      used_ext = {{cffbp_pkg::USED_W{1'b0}}, count_in};
      rsp_in   = rsp_ff;
      if (load) begin
         rsp_in.placed_tag = res_tag;
         rsp_in.bin_index  = bin_ext[cffbp_pkg::IDX_W-1:0];
         rsp_in.opened_new = res_opened;
         rsp_in.status     = res_status;
         rsp_in.fill_after = res_fill;
         rsp_in.bins_used  = used_ext[cffbp_pkg::USED_W-1:0];
         rsp_in.last_out   = res_last;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         class_mem[wr_addr] <= wr_class;
         fill_mem[wr_addr]  <= wr_fill;
      end
      rd_class_ff <= class_mem[rd_addr];
      rd_fill_ff  <= fill_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      cls_ff  <= cls_in;
      size_ff <= size_in;
      tag_ff  <= tag_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

### hw/rtl/class_first_fit_bin_packer.sv
// Top level of the class first-fit bin packer.
// Packs items into up to MAX_BINS bins, first-fit within each item's class, against a
// shared capacity written over the csr port (reset 10.0 in Q8.8). A clear or an
// oversized item passes through the front register, the queue and the back stage's
// result register; a pack item also scans 1 to MAX_BINS open bins in order (none
// while no bin is open), reading one bin per cycle from the single read port of the
// bin store. Items are handled one at a time in the back stage; a front register and
// a two-entry queue keep accepting while a scan runs. The csr register must be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module class_first_fit_bin_packer #(
   parameter int MAX_BINS   = 16,
   parameter int CLASS_BITS = 3
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_command,
   input  wire  [cffbp_pkg::CLS_W-1:0]   req_item_class,
   input  wire  [cffbp_pkg::SIZE_W-1:0]  req_item_size,
   input  wire  [cffbp_pkg::TAG_W-1:0]   req_item_tag,
   input  wire                           req_last_item,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [cffbp_pkg::TAG_W-1:0]   rsp_placed_tag,
   output logic [cffbp_pkg::IDX_W-1:0]   rsp_bin_index,
   output logic                          rsp_opened_new,
   output logic [cffbp_pkg::STAT_W-1:0]  rsp_status,
   output logic [cffbp_pkg::SIZE_W-1:0]  rsp_fill_after,
   output logic [cffbp_pkg::USED_W-1:0]  rsp_bins_used,
   output logic                          rsp_last_out,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [cffbp_pkg::SIZE_W-1:0]  csr_data
);

   logic [cffbp_pkg::SIZE_W-1:0] cap_ff, cap_in;
   logic                         push_valid, push_ready;
   cffbp_pkg::job_type           push_job;
   logic                         q_valid, q_pop;
   cffbp_pkg::job_type           q_job;
   cffbp_pkg::result_type        result;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cffbp_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   cffbp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_item_class (req_item_class),
      .req_item_size  (req_item_size),
      .req_item_tag   (req_item_tag),
      .req_last_item  (req_last_item),
      .capacity       (cap_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job)
   );

   cffbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_job    (q_job)
   );

   cffbp_back #(
      .MAX_BINS   (MAX_BINS),
      .CLASS_BITS (CLASS_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_pop    (q_pop),
      .job        (q_job),
      .capacity   (cap_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   assign rsp_placed_tag = result.placed_tag;
   assign rsp_bin_index  = result.bin_index;
   assign rsp_opened_new = result.opened_new;
   assign rsp_status     = result.status;
   assign rsp_fill_after = result.fill_after;
   assign rsp_bins_used  = result.bins_used;
   assign rsp_last_out   = result.last_out;

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back stage popped an empty queue");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cffbp_pkg::STAT_PLACED) |->
         (rsp_bin_index == '0) && (rsp_fill_after == '0) && !rsp_opened_new)
      else $error("rejected item carries placement fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == cffbp_pkg::STAT_PLACED) ||
         (rsp_status == cffbp_pkg::STAT_OVERSIZE) || (rsp_status == cffbp_pkg::STAT_NO_BIN))
      else $error("result status out of range");

   a_pop_frees_output: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid || !rsp_stall)
      else $error("item popped while a result is held");

endmodule

`default_nettype wire
